[hdl/perceptron_branch_predictor_macros.svh]
// Assertion macros shared by the perceptron branch predictor RTL.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define PBP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pbp: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define PBP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbp: same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define PBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbp: next-cycle implication violated");

`else

`define PBP_ASSERT_ALWAYS(label, cond)
`define PBP_ASSERT_IMPL(label, ante, cons)
`define PBP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/pbp_pkg.sv]
// Types and constants of the perceptron branch predictor.
`default_nettype none

package pbp_pkg;

  // Item kinds
  localparam logic [2:0] KIND_PREDICT = 3'd0;
  localparam logic [2:0] KIND_UNCOND  = 3'd1;
  localparam logic [2:0] KIND_UPDATE  = 3'd2;
  localparam logic [2:0] KIND_SQUASH  = 3'd3;
  localparam logic [2:0] KIND_BTBMISS = 3'd4;

  // Field widths
  localparam int PC_W     = 48;
  localparam int SNAP_W   = 15;
  localparam int PSUM_W   = 12;
  localparam int THRESH_W = 11;

  // Output sum range
  localparam int PERC_SUM_MAX = 2047;
  localparam int PERC_SUM_MIN = -2048;

  // Configuration space
  localparam int             APB_ADDR_W       = 3;
  localparam int             APB_DATA_W       = 32;
  localparam logic           REG_TRAIN_THRESH = 1'b0;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd43;

  typedef struct packed {
    logic [2:0]               kind;
    logic [1:0]               thread;
    logic [PC_W-1:0]          pc;
    logic                     taken;
    logic                     squashed;
    logic [SNAP_W-1:0]        saved_history;
    logic signed [PSUM_W-1:0] saved_sum;
    logic                     saved_prediction;
  } pbp_req_t;

  typedef struct packed {
    logic                     predict_taken;
    logic signed [PSUM_W-1:0] perceptron_sum;
    logic [SNAP_W-1:0]        history_snapshot;
  } pbp_rsp_t;

endpackage

`default_nettype wire

[hdl/perceptron_branch_predictor.sv]
// Perceptron branch direction predictor: weight table, thread histories, training.
//
// Usage:
//   Request channel (req_valid/req_ready/req_data) takes one item per beat:
//   predict, unconditional, update, squash restore or BTB miss. Predict and
//   unconditional items produce one response beat (rsp_valid/rsp_ready/
//   rsp_data); the other kinds produce none.
//   Pipeline: input stage (row index from pc), table read stage (sum, train,
//   history update), response register. One item is taken every cycle unless
//   the reset sweep runs or a response stall backs up; the rate is set by the
//   weight RAM read and the per-thread history loop.
//   A training write to a row read by the very next item is forwarded.
//   Reset: histories clear at once; the weight RAM is then swept to zero,
//   one row per cycle through every row, with req_ready low. APB writes
//   are taken during the sweep.
//   When the response receiver stalls, the response register holds; a predict or
//   unconditional item then halts in the read stage and one more item may enter
//   behind it before req_ready drops. train_threshold sits at APB byte address 0.
`default_nettype none

`include "perceptron_branch_predictor_macros.svh"

module perceptron_branch_predictor #(
  parameter int ENTRIES     = 256,
  parameter int WEIGHTS     = 16,
  parameter int WEIGHT_BITS = 8,
  parameter int THREADS     = 4,
  parameter int INST_SHIFT  = 2
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             req_valid,
  output logic                            req_ready,
  input  pbp_pkg::pbp_req_t               req_data,
  output logic                            rsp_valid,
  input  wire                             rsp_ready,
  output pbp_pkg::pbp_rsp_t               rsp_data,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [pbp_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire [pbp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pbp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import pbp_pkg::*;

  localparam int HIST_LEN = WEIGHTS - 1;
  localparam int ROW_BITS = WEIGHTS * WEIGHT_BITS;
  localparam int ADDR_W   = $clog2(ENTRIES);
  localparam int THR_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int SUM_W    = WEIGHT_BITS + $clog2(WEIGHTS) + 1;
  localparam int SUMX_W   = (SUM_W > PSUM_W) ? SUM_W : PSUM_W;
  localparam int TREE_P   = 1 << $clog2(WEIGHTS);
  localparam int NCHUNK   = PC_W / 8;
  localparam bit POW2     = (ENTRIES & (ENTRIES - 1)) == 0;

  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic signed [SUMX_W-1:0] SUM_HI = SUMX_W'(PERC_SUM_MAX);
  localparam logic signed [SUMX_W-1:0] SUM_LO = SUMX_W'(PERC_SUM_MIN);
  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ENTRIES - 1);

  // Table of (c * 2^(8k)) mod ENTRIES for one byte position k
  function automatic logic [256*ADDR_W-1:0] mod_tbl(input int k);
    logic [256*ADDR_W-1:0] t;
    int r;
    t = '0;
    r = 1 % ENTRIES;
    for (int i = 0; i < 8 * k; i++) begin
      r = (r * 2) % ENTRIES;
    end
    for (int c = 0; c < 256; c++) begin
      t[c*ADDR_W +: ADDR_W] = ADDR_W'((c * r) % ENTRIES);
    end
    return t;
  endfunction

  // Fold a value below twice ENTRIES back into range
  function automatic logic [ADDR_W-1:0] mod_fold(input logic [ADDR_W:0] s);
    logic [ADDR_W:0] d;
    d = (s >= (ADDR_W+1)'(ENTRIES)) ? s - (ADDR_W+1)'(ENTRIES) : s;
    return d[ADDR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  logic [THRESH_W-1:0] train_threshold;
  logic                cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == REG_TRAIN_THRESH);

  // Write the threshold on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      train_threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && cfg_sel) begin
      train_threshold <= pwdata[THRESH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_sel) begin
      prdata = APB_DATA_W'(train_threshold);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  logic            clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic            s0_valid;
  pbp_req_t        s0_item;
  logic            s1_valid;
  pbp_req_t        s1_item;
  logic            s0_adv;
  logic            s1_adv;
  logic            s1_result;
  logic            req_acc;

  assign s1_result = s1_valid &&
                     (s1_item.kind == KIND_PREDICT || s1_item.kind == KIND_UNCOND);
  assign s1_adv    = s1_valid && (!s1_result || !rsp_valid || rsp_ready);
  assign s0_adv    = s0_valid && (!s1_valid || s1_adv);
  assign req_ready = !clearing && (!s0_valid || s0_adv);
  assign req_acc   = req_valid && req_ready;

  // Sweep the weight RAM to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ROW) begin
        clearing <= 1'b0;
      end
    end
  end

  // Advance the input and read stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (req_acc) begin
        s0_valid <= 1'b1;
      end else if (s0_adv) begin
        s0_valid <= 1'b0;
      end
      if (s0_adv) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s0_item <= req_data;
    end
    if (s0_adv) begin
      s1_item <= s0_item;
    end
  end

  // ---------------------------------------------------------------------
  // Row index: (pc >> INST_SHIFT) mod ENTRIES
  // ---------------------------------------------------------------------
  logic [PC_W-1:0]   pc_sh;
  logic [ADDR_W-1:0] s0_row;

  assign pc_sh = s0_item.pc >> INST_SHIFT;

  if (POW2) begin : g_row_mask
    assign s0_row = pc_sh[ADDR_W-1:0];
  end else begin : g_row_fold
    logic [ADDR_W-1:0] part [NCHUNK];
    logic [ADDR_W-1:0] acc  [NCHUNK];

    for (genvar k = 0; k < NCHUNK; k++) begin : g_chunk
      localparam logic [256*ADDR_W-1:0] TBL = mod_tbl(k);
      assign part[k] = TBL[pc_sh[8*k +: 8]*ADDR_W +: ADDR_W];
    end

    // Accumulate the byte residues, folding after each add
    assign acc[0] = part[0];
    for (genvar k = 1; k < NCHUNK; k++) begin : g_acc
      assign acc[k] = mod_fold({1'b0, acc[k-1]} + {1'b0, part[k]});
    end
    assign s0_row = acc[NCHUNK-1];
  end

  // ---------------------------------------------------------------------
  // Weight RAM with forwarding of the row written in the same edge
  // ---------------------------------------------------------------------
  logic [ROW_BITS-1:0] wt_mem [ENTRIES];
  logic [ROW_BITS-1:0] wt_rdata;
  logic [ROW_BITS-1:0] byp_row;
  logic                rd_byp;
  logic [ADDR_W-1:0]   s1_row;
  logic                wt_we;
  logic [ADDR_W-1:0]   wt_waddr;
  logic [ROW_BITS-1:0] wt_wdata;
  logic                upd_we;
  logic [ROW_BITS-1:0] new_row;

  assign wt_we    = clearing || upd_we;
  assign wt_waddr = clearing ? clr_addr : s1_row;
  assign wt_wdata = clearing ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    if (s0_adv) begin
      wt_rdata <= wt_mem[s0_row];
    end
  end

  // Capture the trained row when the next item reads the same row
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_byp <= 1'b0;
    end else if (s0_adv) begin
      rd_byp <= upd_we && (s1_row == s0_row);
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_row  <= s0_row;
      byp_row <= new_row;
    end
  end

  // ---------------------------------------------------------------------
  // Read stage: history, perceptron sum, training
  // ---------------------------------------------------------------------
  logic [ROW_BITS-1:0]          row;
  logic signed [WEIGHT_BITS-1:0] w     [WEIGHTS];
  logic signed [WEIGHT_BITS-1:0] new_w [WEIGHTS];
  logic signed [SUM_W-1:0]      tree  [2*TREE_P];
  logic signed [SUM_W-1:0]      psum;
  logic signed [SUMX_W-1:0]     psumx;
  logic signed [SUMX_W-1:0]     psat;
  logic                         dir;
  logic [HIST_LEN-1:0]          thread_history [THREADS];
  logic [HIST_LEN-1:0]          hist;
  logic [HIST_LEN-1:0]          shist;
  logic [THR_W-1:0]             hist_idx;
  logic                         thr_ok;
  logic                         hist_we;
  logic [HIST_LEN-1:0]          hist_wdata;
  logic [PSUM_W-1:0]            mag;
  logic                         train;
  pbp_rsp_t                     rsp_next;

  assign row      = rd_byp ? byp_row : wt_rdata;
  assign hist_idx = THR_W'(32'(s1_item.thread));
  assign thr_ok   = 32'(s1_item.thread) < THREADS;
  assign hist     = thr_ok ? thread_history[hist_idx] : '0;
  assign shist    = HIST_LEN'(32'(s1_item.saved_history));

  // Split the row and form the signed terms at the tree leaves
  always_comb begin
    for (int j = 0; j < WEIGHTS; j++) begin
      w[j] = row[j*WEIGHT_BITS +: WEIGHT_BITS];
    end
    for (int j = 0; j < TREE_P; j++) begin
      tree[TREE_P+j] = '0;
      if (j == 0) begin
        tree[TREE_P+j] = SUM_W'(w[0]);
      end else if (j < WEIGHTS) begin
        tree[TREE_P+j] = hist[j-1] ? SUM_W'(w[j]) : -SUM_W'(w[j]);
      end
    end
    // Adder tree, root at node 1
    for (int n = TREE_P - 1; n >= 1; n--) begin
      tree[n] = tree[2*n] + tree[2*n+1];
    end
    tree[0] = '0;
  end

  assign psum  = tree[1];
  assign dir   = !psum[SUM_W-1];
  assign psumx = SUMX_W'(psum);

  // Clamp the sum to the output range
  always_comb begin
    psat = psumx;
    if (psumx > SUM_HI) begin
      psat = SUM_HI;
    end else if (psumx < SUM_LO) begin
      psat = SUM_LO;
    end
  end

  // Train when mispredicted or not confident enough
  assign mag   = s1_item.saved_sum[PSUM_W-1] ? (~s1_item.saved_sum + 1'b1)
                                             : s1_item.saved_sum;
  assign train = (s1_item.taken != s1_item.saved_prediction) ||
                 (mag <= {1'b0, train_threshold});

  // Step each weight toward agreement, saturating
  always_comb begin
    logic up;
    for (int j = 0; j < WEIGHTS; j++) begin
      up = (j == 0) ? s1_item.taken : (s1_item.taken == shist[(j == 0) ? 0 : j-1]);
      if (up) begin
        new_w[j] = (w[j] == W_MAX) ? w[j] : w[j] + 1'b1;
      end else begin
        new_w[j] = (w[j] == W_MIN) ? w[j] : w[j] - 1'b1;
      end
      new_row[j*WEIGHT_BITS +: WEIGHT_BITS] = new_w[j];
    end
  end

  // Decode the item kind into history writes, table writes and the response
  always_comb begin
    hist_we    = 1'b0;
    hist_wdata = hist;
    upd_we     = 1'b0;
    rsp_next   = '0;
    rsp_next.history_snapshot = SNAP_W'(32'(hist));
    case (s1_item.kind)
      KIND_PREDICT: begin
        hist_we                 = 1'b1;
        hist_wdata              = HIST_LEN'({hist, dir});
        rsp_next.predict_taken  = dir;
        rsp_next.perceptron_sum = psat[PSUM_W-1:0];
      end
      KIND_UNCOND: begin
        hist_we                 = 1'b1;
        hist_wdata              = HIST_LEN'({hist, 1'b1});
        rsp_next.predict_taken  = 1'b1;
        rsp_next.perceptron_sum = PSUM_W'(1);
      end
      KIND_UPDATE: begin
        upd_we     = s1_adv && train;
        hist_we    = s1_item.squashed;
        hist_wdata = HIST_LEN'({shist, s1_item.taken});
      end
      KIND_SQUASH: begin
        hist_we    = 1'b1;
        hist_wdata = shist;
      end
      KIND_BTBMISS: begin
        hist_we    = 1'b1;
        hist_wdata = hist & ~HIST_LEN'(1);
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  // Commit the thread history when the item leaves the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < THREADS; t++) begin
        thread_history[t] <= '0;
      end
    end else if (s1_adv && hist_we && thr_ok) begin
      thread_history[hist_idx] <= hist_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv && s1_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_result) begin
      rsp_data <= rsp_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `PBP_ASSERT_ALWAYS(a_clear_pipe_empty, !(clearing && (s0_valid || s1_valid)))
  `PBP_ASSERT_NEXT(a_clear_done, clearing && (clr_addr == LAST_ROW), !clearing)
  `PBP_ASSERT_IMPL(a_no_train_on_stall, s1_valid && !s1_adv, !wt_we)
  `PBP_ASSERT_NEXT(a_rsp_follows_result, s1_adv && s1_result, rsp_valid)

endmodule

`default_nettype wire
